// ===== design/ats_pkg.sv =====
package ats_pkg;
  localparam int MaxCategories = 128;
  localparam int WeightBits    = 16;
  localparam int FractionBits  = 16;
  localparam int ScaledBits    = 23;
  localparam int CountBits     = 8;
  localparam int IndexBits     = 7;
  localparam int StatusBits    = 2;

  localparam logic [StatusBits-1:0] StatusOk       = 2'd0;
  localparam logic [StatusBits-1:0] StatusNotBuilt = 2'd1;
  localparam logic [StatusBits-1:0] StatusZero     = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpDraw = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_RD,
    ST_SCALE_DIV,
    ST_SCALE_WR,
    ST_PAIR_POP,
    ST_PAIR_RD,
    ST_PAIR_WR,
    ST_LEFT,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } seq_state_t;
endpackage

// ===== design/ats_if.sv =====
interface ats_in_if #(
  parameter int WEIGHT_BITS   = 16,
  parameter int FRACTION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [WEIGHT_BITS-1:0]   weight;
  logic [FRACTION_BITS-1:0] uniform_pick;
  logic [FRACTION_BITS-1:0] uniform_accept;
  modport source (output valid, op, weight, uniform_pick, uniform_accept, input ready);
  modport sink (input valid, op, weight, uniform_pick, uniform_accept, output ready);
endinterface

interface ats_out_if #(
  parameter int INDEX_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] drawn_index;
  logic [1:0]            status;
  modport source (output valid, drawn_index, status, input ready);
  modport sink (input valid, drawn_index, status, output ready);
endinterface

// ===== design/ats_divider.sv =====
// restoring divider, one quotient bit per cycle
module ats_divider #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                busy,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CntBits = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] num_sh;
  logic [DEN_BITS-1:0] rem;
  logic [CntBits-1:0]  cnt;
  logic [DEN_BITS:0]   trial;

  assign trial = {rem, num_sh[NUM_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= CntBits'(NUM_BITS);
      num_sh <= numer;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      if (trial >= {1'b0, denom}) begin
        rem  <= DEN_BITS'(trial - {1'b0, denom});
        quot <= {quot[NUM_BITS-2:0], 1'b1};
      end else begin
        // remainder below the divisor, top bit is zero
        rem  <= trial[DEN_BITS-1:0];
        quot <= {quot[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) busy <= 1'b0;
    end
  end
endmodule

// ===== design/alias_table_discrete_sampler.sv =====
// Vose alias sampler. Each load word is stored; the last of a set
// (category_count words) also starts the table build: scaling of every
// weight through one shared bit-serial divider, whose numerator width is
// scaled width + count width + fraction bits, then small/large pairing and
// then the leftover entries; a zero total ends the build at its first scale
// read; input is held off during the build. A draw does one table memory
// read and its result sits in an output register; the next word is taken
// once that result is gone. Draws before a build report status 1, draws on a
// zero total report status 2 with index 0.
module alias_table_discrete_sampler #(
  parameter int MAX_CATEGORIES = ats_pkg::MaxCategories,
  parameter int WEIGHT_BITS    = ats_pkg::WeightBits,
  parameter int FRACTION_BITS  = ats_pkg::FractionBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ats_pkg::CountBits-1:0] cfg_wdata,
  ats_in_if.sink                        in_ch,
  ats_out_if.source                     out_ch
);
  import ats_pkg::*;

  localparam int AW     = $clog2(MAX_CATEGORIES);
  localparam int NB     = $clog2(MAX_CATEGORIES + 1);
  localparam int SW     = ScaledBits;
  localparam int TotW   = WEIGHT_BITS + NB;
  localparam int NumW   = SW + NB + FRACTION_BITS;
  localparam int ThrW   = FRACTION_BITS + 1;
  localparam logic [SW-1:0] FixOne    = SW'(1) << FRACTION_BITS;
  localparam logic [SW-1:0] ScaledMax = '1;

  // configuration and load state
  logic [CountBits-1:0] count_reg;
  logic [NB-1:0]        n_act;
  logic [NB-1:0]        loaded;
  logic [TotW-1:0]      total;
  logic                 ready_tbl, zero_tot;
  seq_state_t           state, state_next;

  always_comb begin
    if (count_reg == '0) n_act = NB'(1);
    else if (32'(count_reg) > MAX_CATEGORIES) n_act = NB'(MAX_CATEGORIES);
    else n_act = NB'(count_reg);
  end

  // memories: scaled weights, thresholds, aliases, two stacks
  logic [SW-1:0]   wmem [MAX_CATEGORIES];
  logic [ThrW-1:0] tmem [MAX_CATEGORIES];
  logic [AW-1:0]   amem [MAX_CATEGORIES];
  logic [AW-1:0]   smem [MAX_CATEGORIES];
  logic [AW-1:0]   lmem [MAX_CATEGORIES];

  logic [NB-1:0]  sdep, ldep, idx;
  logic [AW-1:0]  lo, hi;
  logic [SW-1:0]  wlo, whi, wrd;
  logic [FRACTION_BITS-1:0] acc_q;
  logic [AW-1:0]  col;
  logic [ThrW-1:0] thr_rd;
  logic [AW-1:0]   ali_rd;
  logic            out_v;
  logic [IndexBits-1:0]  out_idx;
  logic [StatusBits-1:0] out_st;

  // divider shared by all scale steps
  logic            div_start, div_busy;
  logic [NumW-1:0] div_q;
  logic [NumW-1:0] numer;
  assign numer = NumW'(wrd) * NumW'(n_act) << FRACTION_BITS;

  ats_divider #(.NUM_BITS(NumW), .DEN_BITS(TotW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(numer), .denom(total),
    .busy(div_busy), .quot(div_q)
  );

  logic [SW-1:0] scaled;
  assign scaled = (div_q > NumW'(ScaledMax)) ? ScaledMax : SW'(div_q);

  logic in_fire;
  assign in_ch.ready = (state == ST_IDLE) && !out_v;
  assign in_fire     = in_ch.valid && in_ch.ready;

  logic [FRACTION_BITS+NB-1:0] pick_prod;
  assign pick_prod = (FRACTION_BITS+NB)'(n_act) * (FRACTION_BITS+NB)'(in_ch.uniform_pick);

  logic [NB-1:0] k_raw;
  assign k_raw = pick_prod[FRACTION_BITS +: NB];

  logic fresh;
  assign fresh = ready_tbl || (loaded >= n_act);

  // new-hi weight after pairing
  logic [SW-1:0] whi_new;
  assign whi_new = whi + wlo - FixOne;

  // registered divider busy, used to see that busy has just fallen
  logic div_was;
  always_ff @(posedge clk) begin
    if (rst) div_was <= 1'b0;
    else div_was <= div_busy;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_ch.op == OpDraw && ready_tbl && !zero_tot) state_next = ST_DRAW_RD;
        else if (in_fire && in_ch.op == OpLoad &&
                 ((fresh ? NB'(1) : loaded + 1'b1) == n_act)) begin
          state_next = ST_SCALE_RD;
        end
      end
      ST_SCALE_RD: state_next = (total == '0) ? ST_IDLE : ST_SCALE_DIV;
      ST_SCALE_DIV: begin
        div_start  = 1'b1;
        state_next = ST_SCALE_WR;
      end
      ST_SCALE_WR: begin
        if (!div_start && !div_busy && div_was) begin
          state_next = (idx + 1'b1 == n_act) ? ST_PAIR_POP : ST_SCALE_RD;
        end
      end
      ST_PAIR_POP: state_next = (sdep != '0 && ldep != '0) ? ST_PAIR_RD :
                                ((sdep != '0 || ldep != '0) ? ST_LEFT : ST_IDLE);
      ST_PAIR_RD:  state_next = ST_PAIR_WR;
      ST_PAIR_WR:  state_next = ST_PAIR_POP;
      ST_LEFT:     state_next = ST_PAIR_POP;
      ST_DRAW_RD:  state_next = ST_DRAW_OUT;
      ST_DRAW_OUT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count_reg <= CountBits'(1);
      loaded    <= '0;
      total     <= '0;
      ready_tbl <= 1'b0;
      zero_tot  <= 1'b0;
      sdep      <= '0;
      ldep      <= '0;
      out_v     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_v && out_ch.ready) out_v <= 1'b0;
      if (cfg_we) begin
        count_reg <= cfg_wdata;
        loaded    <= '0;
        total     <= '0;
        ready_tbl <= 1'b0;
        zero_tot  <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_ch.op == OpLoad) begin
            if (fresh) begin
              ready_tbl <= 1'b0;
              zero_tot  <= 1'b0;
              loaded    <= NB'(1);
              total     <= TotW'(in_ch.weight);
            end else begin
              loaded <= loaded + 1'b1;
              total  <= total + TotW'(in_ch.weight);
            end
            wmem[AW'(fresh ? '0 : loaded)] <= SW'(in_ch.weight);
            idx  <= '0;
            sdep <= '0;
            ldep <= '0;
          end else if (in_fire) begin
            if (!ready_tbl || zero_tot) begin
              out_v   <= 1'b1;
              out_idx <= '0;
              out_st  <= ready_tbl ? StatusZero : StatusNotBuilt;
            end
            col   <= (k_raw >= n_act) ? AW'(n_act - 1'b1) : AW'(k_raw);
            acc_q <= in_ch.uniform_accept;
          end
        end
        ST_SCALE_RD: begin
          if (!ready_tbl) begin
            ready_tbl <= 1'b1;
            zero_tot  <= (total == '0);
          end
          wrd <= wmem[AW'(idx)];
        end
        ST_SCALE_DIV: ;
        ST_SCALE_WR: begin
          if (!div_busy && div_was) begin
            wmem[AW'(idx)] <= scaled;
            if (scaled < FixOne) begin
              smem[AW'(sdep)] <= AW'(idx);
              sdep <= sdep + 1'b1;
            end else begin
              lmem[AW'(ldep)] <= AW'(idx);
              ldep <= ldep + 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        ST_PAIR_POP: begin
          if (sdep != '0 && ldep != '0) begin
            lo   <= smem[AW'(sdep - 1'b1)];
            hi   <= lmem[AW'(ldep - 1'b1)];
            sdep <= sdep - 1'b1;
            ldep <= ldep - 1'b1;
          end else if (ldep != '0) begin
            // leftover large entries first, then leftover small ones
            lo   <= lmem[AW'(ldep - 1'b1)];
            ldep <= ldep - 1'b1;
          end else if (sdep != '0) begin
            lo   <= smem[AW'(sdep - 1'b1)];
            sdep <= sdep - 1'b1;
          end
        end
        ST_PAIR_RD: begin
          wlo <= wmem[lo];
          whi <= wmem[hi];
        end
        ST_PAIR_WR: begin
          tmem[lo] <= ThrW'(wlo);
          amem[lo] <= hi;
          wmem[hi] <= whi_new;
          if (whi_new < FixOne) begin
            smem[AW'(sdep)] <= hi;
            sdep <= sdep + 1'b1;
          end else begin
            lmem[AW'(ldep)] <= hi;
            ldep <= ldep + 1'b1;
          end
        end
        ST_LEFT: begin
          // leftover entry: threshold 1.0, aliases itself
          tmem[lo] <= ThrW'(FixOne);
          amem[lo] <= lo;
        end
        ST_DRAW_RD: begin
          thr_rd <= tmem[col];
          ali_rd <= amem[col];
        end
        ST_DRAW_OUT: begin
          out_v   <= 1'b1;
          out_st  <= StatusOk;
          out_idx <= IndexBits'((ThrW'(acc_q) < thr_rd) ? col : ali_rd);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = out_v;
  assign out_ch.drawn_index = out_idx;
  assign out_ch.status      = out_st;

`ifndef ASSERT_OFF
  // no new word while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_v |-> !in_ch.ready) else $error("input taken with result pending");
  // combined stack depth never exceeds the maximum category count
  a_depth: assert property (@(posedge clk) disable iff (rst)
    (sdep + ldep) <= NB'(MAX_CATEGORIES)) else $error("stack overflow");
  // ok results only come from built nonzero tables
  a_ok_built: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_st == StatusOk) |-> (ready_tbl && !zero_tot))
    else $error("ok draw without tables");
`endif
endmodule
